FILE: hw/rtl/sphere_contact_generator_assert.svh
// Assertion macros shared by the contact generator RTL.
// Needs clk and rst in scope where a macro is used.
`ifndef SPHERE_CONTACT_GENERATOR_ASSERT_SVH
`define SPHERE_CONTACT_GENERATOR_ASSERT_SVH

// Checked property, off while reset is high
`define SCG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked property, also active during reset
`define SCG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/scg_pkg.sv
// Shared types and constants of the sphere contact generator.
// No dependencies; used by every module of the block.
package scg_pkg;

  // Pair kinds carried on the input tuser
  localparam logic CMD_SPHERE = 1'b0;
  localparam logic CMD_PLANE  = 1'b1;

  localparam int IN_DATA_W  = 304;
  localparam int OUT_DATA_W = 80;

  // Request as it sits in the queue between front and back
  typedef struct packed {
    logic             cmd;
    logic [2:0][32:0] d;      // first - second, signed
    logic [2:0][32:0] dmag;   // magnitude of d
    logic [2:0][15:0] pn;     // plane normal
    logic [30:0]      r1;
    logic [30:0]      r2;
  } item_t;

  // Queue flags seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Working set carried down the back pipeline
  typedef struct packed {
    logic             cmd;
    logic [2:0][32:0] d;
    logic [2:0][32:0] dmag;
    logic [2:0][15:0] pn;
    logic [30:0]      r1;
    logic [30:0]      r2;
    logic [2:0][65:0] sq;
    logic [2:0][48:0] pr;
    logic [67:0]      rad;    // radicand, then sqrt remainder
    logic [50:0]      dot;
    logic [49:0]      absdot;
    logic [36:0]      proj;
    logic             phit;
    logic [31:0]      pdepth;
    logic [35:0]      root;
    logic             shit;
    logic [31:0]      sdepth;
    logic [2:0][36:0] divr;
    logic [2:0][14:0] divn;
    logic [2:0][14:0] quo;
  } bk_t;

endpackage

FILE: hw/rtl/sphere_contact_generator.sv
// Sphere-sphere and plane-sphere contact test, one pair per request. It takes a
// new request every cycle while the queue has room and returns one result per
// request, in order. Most of the pipeline is the square root, which resolves one
// bit of the 36-bit center distance per stage, followed by a 15-stage divider
// that forms the three normal components in parallel. A four-entry queue sits
// between the input stage and the pipeline, so input ready does not depend on
// output ready. No state survives between requests.
// Depends on scg_pkg, scg_front, scg_queue, scg_back and the assertion header.
`include "sphere_contact_generator_assert.svh"

module sphere_contact_generator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, first_radius,
  // second_radius, plane_nx, plane_ny, plane_nz, 2 zero bits
  input  logic [scg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // depth, contact_nx, contact_ny, contact_nz
  output logic [scg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // touching
  output logic                           m_axis_tuser
);

  scg_pkg::q_stat_t q_stat;
  scg_pkg::item_t   push_item;
  scg_pkg::item_t   pop_item;
  logic             push;
  logic             pop;

  scg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  scg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  scg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .q_item        (pop_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Checks
  `SCG_ASSERT(a_no_contact_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "result without contact carries nonzero fields")
  `SCG_ASSERT(a_contact_depth, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] != 32'd0, "contact reported with zero depth")
  `SCG_ASSERT(a_queue_flags, !(q_stat.full && q_stat.empty), "queue full and empty at once")
  `SCG_ASSERT(a_stall_cause, !s_axis_tready |-> q_stat.full, "input stalled while queue has room")

endmodule

FILE: hw/rtl/scg_front.sv
// Front end: takes requests, unpacks them and forms center differences.
// Depends on scg_pkg; feeds scg_queue.
module scg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [scg_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  scg_pkg::q_stat_t              q_stat,
  output logic                          push,
  output scg_pkg::item_t                push_item
);

  logic           f_valid;
  scg_pkg::item_t f_item;
  scg_pkg::item_t item_next;
  logic           ce;

  assign ce            = !f_valid || !q_stat.full;
  assign s_axis_tready = ce;
  assign push          = f_valid && !q_stat.full;
  assign push_item     = f_item;

  // Unpack and subtract; magnitudes for the squares downstream
  always_comb begin
    item_next     = '0;
    item_next.cmd = s_axis_tuser;
    for (int i = 0; i < 3; i++) begin
      item_next.d[i] = {s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]}
                     - {s_axis_tdata[32*i+127], s_axis_tdata[32*i+96 +: 32]};
      item_next.dmag[i] = item_next.d[i][32] ? (33'd0 - item_next.d[i]) : item_next.d[i];
      item_next.pn[i]   = s_axis_tdata[254+16*i +: 16];
    end
    item_next.r1 = s_axis_tdata[222:192];
    item_next.r2 = s_axis_tdata[253:223];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (ce) begin
      f_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      f_item <= item_next;
    end
  end

endmodule

FILE: hw/rtl/scg_queue.sv
// Short request queue between the front end and the back pipeline.
// Depends on scg_pkg.
module scg_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  scg_pkg::item_t   push_item,
  input  logic             pop,
  output scg_pkg::item_t   pop_item,
  output scg_pkg::q_stat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  scg_pkg::item_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign q_stat.full  = (count == CW'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_item     = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: hw/rtl/scg_back.sv
// Back pipeline: squares, plane dot product, bit-per-stage square root,
// bit-per-stage normal divide and the output register. Depends on scg_pkg.
module scg_back (
  input  logic                           clk,
  input  logic                           rst,
  input  scg_pkg::q_stat_t               q_stat,
  input  scg_pkg::item_t                 q_item,
  output logic                           pop,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [scg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tuser
);

  localparam int ROOT_BITS = 36;
  localparam int QUO_BITS  = 15;
  localparam int S_MUL = 1;
  localparam int S_ADD = 2;
  localparam int S_ABS = 3;
  localparam int S_RND = 4;
  localparam int S_PLN = 5;
  localparam int S_SQ0 = 6;
  localparam int S_CMP = S_SQ0 + ROOT_BITS;
  localparam int S_DV0 = S_CMP + 1;
  localparam int NST   = S_DV0 + QUO_BITS - 1;

  scg_pkg::bk_t st [1:NST];
  logic [NST:1] vld;
  scg_pkg::bk_t in_bk;
  logic         ce;
  logic [scg_pkg::OUT_DATA_W-1:0] data_next;
  logic         user_next;

  // Whole pipeline advances unless the output register is blocked
  assign ce  = !m_axis_tvalid || m_axis_tready;
  assign pop = ce && !q_stat.empty;

  always_comb begin
    in_bk      = '0;
    in_bk.cmd  = q_item.cmd;
    in_bk.d    = q_item.d;
    in_bk.dmag = q_item.dmag;
    in_bk.pn   = q_item.pn;
    in_bk.r1   = q_item.r1;
    in_bk.r2   = q_item.r2;
  end

  // Work done by pipeline stage k
  function automatic scg_pkg::bk_t stage_fn(input int k, input scg_pkg::bk_t x);
    scg_pkg::bk_t y;
    int           b;
    logic [71:0]  trial;
    logic [50:0]  rnd;
    logic [31:0]  rsum;
    logic [47:0]  numer;
    logic [36:0]  t;
    y = x;
    if (k == S_MUL) begin
      for (int i = 0; i < 3; i++) begin
        y.sq[i] = {33'd0, x.dmag[i]} * {33'd0, x.dmag[i]};
        y.pr[i] = $signed({{16{x.d[i][32]}}, x.d[i]})
                * $signed({{33{x.pn[i][15]}}, x.pn[i]});
      end
    end else if (k == S_ADD) begin
      y.rad = {2'b0, x.sq[0]} + {2'b0, x.sq[1]} + {2'b0, x.sq[2]};
      y.dot = {{2{x.pr[0][48]}}, x.pr[0]} + {{2{x.pr[1][48]}}, x.pr[1]}
            + {{2{x.pr[2][48]}}, x.pr[2]};
    end else if (k == S_ABS) begin
      y.absdot = x.dot[50] ? 50'(51'd0 - x.dot) : x.dot[49:0];
    end else if (k == S_RND) begin
      rnd    = {1'b0, x.absdot} + 51'd8192;
      y.proj = rnd[50:14];
    end else if (k == S_PLN) begin
      y.phit   = {6'd0, x.r2} > x.proj;
      y.pdepth = {1'b0, x.r2} - x.proj[31:0];
    end else if (k >= S_SQ0 && k < S_CMP) begin
      // one root bit per stage, remainder kept as rad
      b     = S_CMP - 1 - k;
      trial = ({36'd0, x.root} << (b + 1)) + (72'd1 << (2 * b));
      if ({4'd0, x.rad} >= trial) begin
        y.rad  = x.rad - trial[67:0];
        y.root = x.root | (36'd1 << b);
      end
    end else if (k == S_CMP) begin
      rsum     = {1'b0, x.r1} + {1'b0, x.r2};
      y.shit   = {4'd0, rsum} > x.root;
      y.sdepth = rsum - x.root[31:0];
      for (int i = 0; i < 3; i++) begin
        numer     = {1'b0, x.dmag[i], 14'd0} + {13'd0, x.root[35:1]};
        y.divr[i] = {4'd0, numer[47:15]};
        y.divn[i] = numer[14:0];
        y.quo[i]  = '0;
      end
    end else if (k >= S_DV0) begin
      // restoring divide, one quotient bit per stage
      for (int i = 0; i < 3; i++) begin
        t = {x.divr[i][35:0], x.divn[i][14]};
        if (t >= {1'b0, x.root}) begin
          y.divr[i] = t - {1'b0, x.root};
          y.quo[i]  = {x.quo[i][13:0], 1'b1};
        end else begin
          y.divr[i] = t;
          y.quo[i]  = {x.quo[i][13:0], 1'b0};
        end
        y.divn[i] = {x.divn[i][13:0], 1'b0};
      end
    end
    return y;
  endfunction

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NST-1:1], pop};
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (ce) begin
      st[1] <= stage_fn(S_MUL, in_bk);
      for (int k = 2; k <= NST; k++) begin
        st[k] <= stage_fn(k, st[k-1]);
      end
    end
  end

  // Result selection and packing
  always_comb begin
    data_next = '0;
    user_next = 1'b0;
    if (st[NST].cmd == scg_pkg::CMD_PLANE) begin
      if (st[NST].phit) begin
        user_next          = 1'b1;
        data_next[31:0]    = st[NST].pdepth;
        data_next[47:32]   = st[NST].pn[0];
        data_next[63:48]   = st[NST].pn[1];
        data_next[79:64]   = st[NST].pn[2];
      end
    end else if (st[NST].shit) begin
      user_next       = 1'b1;
      data_next[31:0] = st[NST].sdepth;
      if (st[NST].root != '0) begin
        for (int i = 0; i < 3; i++) begin
          data_next[32+16*i +: 16] = st[NST].d[i][32] ? (16'd0 - {1'b0, st[NST].quo[i]})
                                                       : {1'b0, st[NST].quo[i]};
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ce) begin
      m_axis_tvalid <= vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_axis_tdata <= data_next;
      m_axis_tuser <= user_next;
    end
  end

endmodule

FILE: tb/sphere_contact_generator_test.sv
// Testbench for sphere_contact_generator: streams pair requests, predicts each contact
// result in-house and checks results in order. Depends on scg_pkg and the block RTL.
`timescale 1ns / 100ps

module sphere_contact_generator_test;

  typedef struct packed {
    logic        touching;
    logic [31:0] depth;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
  } contact_t;

  typedef struct {
    logic        cmd;
    logic [31:0] p1 [3];
    logic [31:0] p2 [3];
    logic [30:0] r1;
    logic [30:0] r2;
    logic [15:0] pn [3];
  } pair_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [scg_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [scg_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  contact_t expected_contacts[$];
  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;

  sphere_contact_generator uut (.*);

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** sphere_contact_generator: FAILED **");
      $finish;
    end
  end

  // Integer square root floor, 36-bit result
  function automatic logic [35:0] isqrt(logic [67:0] s);
    logic [35:0] res;
    logic [35:0] c;
    res = '0;
    for (int b = 35; b >= 0; b--) begin
      c = res | (36'd1 << b);
      if ({36'd0, c} * {36'd0, c} <= {4'd0, s}) res = c;
    end
    return res;
  endfunction

  // Normal component d/cdist in Q2.14, rounded half away from zero
  function automatic logic [15:0] unit_comp(logic signed [33:0] d, logic [35:0] cdist);
    logic [63:0] m;
    logic [63:0] q;
    m = d < 0 ? -d : d;
    q = (m * 64'd16384 + cdist / 2) / cdist;
    return d < 0 ? 16'(-q) : 16'(q);
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    logic signed [33:0] d [3];
    logic [67:0] sum;
    logic [35:0] cdist;
    logic [32:0] rsum;
    logic signed [63:0] dot;
    logic [63:0] proj;
    c = '0;
    for (int i = 0; i < 3; i++)
      d[i] = $signed({p.p1[i][31], p.p1[i]}) - $signed({p.p2[i][31], p.p2[i]});
    if (p.cmd == scg_pkg::CMD_SPHERE) begin
      sum = '0;
      for (int i = 0; i < 3; i++) sum += 68'(68'(d[i]) * 68'(d[i]));
      cdist = isqrt(sum);
      rsum = {2'b0, p.r1} + {2'b0, p.r2};
      if (36'(rsum) > cdist) begin
        c.depth = 32'(36'(rsum) - cdist);
        if (cdist != 0) begin
          c.nx = unit_comp(d[0], cdist);
          c.ny = unit_comp(d[1], cdist);
          c.nz = unit_comp(d[2], cdist);
        end
      end
    end else begin
      dot = 0;
      for (int i = 0; i < 3; i++) dot += 64'(d[i]) * 64'($signed(p.pn[i]));
      proj = ((dot < 0 ? -dot : dot) + 64'd8192) >> 14;
      if (64'(p.r2) > proj) begin
        c.depth = 32'(64'(p.r2) - proj);
        c.nx = p.pn[0];
        c.ny = p.pn[1];
        c.nz = p.pn[2];
      end
    end
    c.touching = c.depth != 0;
    return c;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // Result checker and receiver stalls
  always @(posedge clk) begin
    contact_t got;
    contact_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tdata[63:48],
             m_axis_tdata[79:64]};
      if (expected_contacts.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = expected_contacts.pop_front();
        if (got.touching !== want.touching) begin
          $error("touching: expected %0d actual %0d", want.touching, got.touching);
          errors++;
        end
        if (got.depth !== want.depth) begin
          $error("depth: expected %h actual %h", want.depth, got.depth);
          errors++;
        end
        if (got.nx !== want.nx) begin
          $error("contact_nx: expected %h actual %h", want.nx, got.nx);
          errors++;
        end
        if (got.ny !== want.ny) begin
          $error("contact_ny: expected %h actual %h", want.ny, got.ny);
          errors++;
        end
        if (got.nz !== want.nz) begin
          $error("contact_nz: expected %h actual %h", want.nz, got.nz);
          errors++;
        end
      end
    end
  end

  int rx_wait = 0;
  bit rx_steady = 0;
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rx_wait <= gap_len();
    end
  end

  bit tx_steady = 0;

  // Send one request; waits for acceptance, then maybe idles
  task automatic send_pair(pair_t p);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= p.cmd;
    s_axis_tdata <= {2'b0, p.pn[2], p.pn[1], p.pn[0], p.r2, p.r1,
                     p.p2[2], p.p2[1], p.p2[0], p.p1[2], p.p1[1], p.p1[0]};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_contacts.push_back(predict_contact(p));
    if (!tx_steady && $urandom_range(0, 2) == 0) begin
      gap = gap_len();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) << 12;
    endcase
  endfunction

  function automatic logic [15:0] rnd_normal();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom());
    if (k < 4) return 16'(k == 1 ? 16384 : (k == 2 ? -16384 : 0));
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic pair_t rnd_pair();
    pair_t p;
    int mode;
    mode = $urandom_range(0, 2);
    p.cmd = 1'($urandom_range(0, 1));
    for (int i = 0; i < 3; i++) begin
      p.p1[i] = rnd_coord(mode);
      p.p2[i] = (mode == 0) ? rnd_coord(0) : p.p1[i] + rnd_coord(mode == 1 ? 2 : 2);
      p.pn[i] = rnd_normal();
    end
    if (mode == 0) begin
      p.r1 = 31'($urandom());
      p.r2 = 31'($urandom());
    end else begin
      p.r1 = 31'($urandom_range(0, 8 << 16));
      p.r2 = 31'($urandom_range(0, 8 << 16));
    end
    if ($urandom_range(0, 15) == 0) p.p2 = p.p1;
    return p;
  endfunction

  function automatic pair_t make_pair(logic cmd, logic [31:0] a, logic [31:0] b,
                                      logic [30:0] r1, logic [30:0] r2, logic [15:0] n);
    pair_t p;
    p.cmd = cmd;
    p.p1 = '{a, a, a};
    p.p2 = '{b, b, b};
    p.r1 = r1;
    p.r2 = r2;
    p.pn = '{n, 16'(-n), 16'h0000};
    return p;
  endfunction

  task automatic wait_drained();
    while (expected_contacts.size() != 0) @(posedge clk);
  endtask

  // Extremes, coincident centers, zero radii, odd plane normals
  task automatic test_directed();
    pair_t p;
    for (int c = 0; c < 2; c++) begin
      send_pair(make_pair(1'(c), 32'h7FFFFFFF, 32'h80000000, '1, '1, 16'h4000));
      send_pair(make_pair(1'(c), 32'h80000000, 32'h7FFFFFFF, '1, '1, 16'hC000));
      send_pair(make_pair(1'(c), 32'h00010000, 32'h00010000, 31'h10000, 31'h8000, 16'h2D41));
      send_pair(make_pair(1'(c), 32'h00000000, 32'h00000000, '0, '0, 16'h0000));
      send_pair(make_pair(1'(c), 32'hFFFFFFFF, 32'h0000_0000, '1, '0, 16'h7FFF));
      send_pair(make_pair(1'(c), 32'h00030000, 32'h00000000, 31'h20000, 31'h10000, 16'h8000));
      send_pair(make_pair(1'(c), 32'h00020000, 32'hFFFF0000, 31'h0, 31'h40000, 16'hFFFF));
      send_pair(make_pair(1'(c), 32'h55555555, 32'hAAAAAAAA, 31'h2AAAAAAA, 31'h55555555,
                          16'h5555));
    end
    p = make_pair(scg_pkg::CMD_SPHERE, 32'h00010000, 32'h0, 31'h10000, 31'h1, 16'h0);
    p.p1[1] = '0;
    p.p1[2] = '0;
    send_pair(p);
    p.cmd = scg_pkg::CMD_PLANE;
    p.pn = '{16'h4000, 16'h0, 16'h0};
    send_pair(p);
    s_axis_tvalid <= 1'b0;
    wait_drained();
  endtask

  // Receiver holds off long while the sender keeps offering requests
  task automatic test_backpressure();
    hold_cycles <= 200;
    tx_steady = 1;
    for (int i = 0; i < 100; i++) send_pair(rnd_pair());
    tx_steady = 0;
  endtask

  // Sender pauses until every pending result has come back
  task automatic test_pause_drain();
    for (int i = 0; i < 20; i++) send_pair(rnd_pair());
    s_axis_tvalid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 100) rx_steady = ~rx_steady;
      send_pair(rnd_pair());
    end
    rx_steady = 0;
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_pause_drain();
    test_random(510);
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_contacts.size() == 0) begin
      $display("** sphere_contact_generator: PASSED **");
    end else begin
      $display("** sphere_contact_generator: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/scg_pkg.sv
hw/rtl/scg_front.sv
hw/rtl/scg_queue.sv
hw/rtl/scg_back.sv
hw/rtl/sphere_contact_generator.sv
tb/sphere_contact_generator_test.sv
